// ----- hw/rtl/rsk_pkg.sv -----
// ----------------------------------------------------------------------------
// rsk_pkg: shared types and constants of the record sorter
// Field widths, the record held by each sorting cell and the cell control.
// ----------------------------------------------------------------------------
package rsk_pkg;

  localparam int KEY_HIGH_W      = 64;
  localparam int KEY_LOW_W       = 24;
  localparam int WEIGHT_W        = 31;
  localparam int INDEX_W         = 6;
  localparam int KEY_W           = KEY_HIGH_W + KEY_LOW_W;
  localparam int KEY_BYTES       = KEY_W / 8;
  localparam int MAX_RECORDS_DEF = 64;
  localparam int KEY_CHARS_DEF   = 11;

  // One stored record. The key is packed so that an unsigned compare of
  // the whole field matches string order.
  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key;
    logic [WEIGHT_W-1:0] weight;
    logic [INDEX_W-1:0]  index;
  } rec_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // a new record is placed into the sorted chain
    logic shift;   // the chain moves one place toward the head
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/rsk_if.sv -----
// ----------------------------------------------------------------------------
// rsk_if: stream interfaces of the record sorter
// Valid/ready channels for loaded records and for sorted results.
// ----------------------------------------------------------------------------
interface rsk_in_if;
  import rsk_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KEY_HIGH_W-1:0] key_high;
  logic [KEY_LOW_W-1:0]  key_low;
  logic [WEIGHT_W-1:0]   weight;
  logic                  last_in;

  modport source (output valid, key_high, key_low, weight, last_in, input ready);
  modport sink   (input valid, key_high, key_low, weight, last_in, output ready);
endinterface

interface rsk_out_if;
  import rsk_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KEY_HIGH_W-1:0] out_key_high;
  logic [KEY_LOW_W-1:0]  out_key_low;
  logic [WEIGHT_W-1:0]   out_weight;
  logic [INDEX_W-1:0]    arrival_index;
  logic                  last_out;

  modport source (output valid, out_key_high, out_key_low, out_weight, arrival_index,
                  last_out, input ready);
  modport sink   (input valid, out_key_high, out_key_low, out_weight, arrival_index,
                  last_out, output ready);
endinterface

// ----- hw/rtl/rsk_normalize.sv -----
// ----------------------------------------------------------------------------
// rsk_normalize: key normalizer
// Clears every character from the first zero character or past the key
// length onward, so that a packed compare matches string compare.
// ----------------------------------------------------------------------------
module rsk_normalize #(
  parameter int KEY_CHARS = rsk_pkg::KEY_CHARS_DEF
) (
  input  logic [rsk_pkg::KEY_W-1:0] key_i,
  output logic [rsk_pkg::KEY_W-1:0] key_o
);
  import rsk_pkg::*;

  always_comb begin
    logic       ended;
    logic [7:0] ch;
    ended = 1'b0;
    key_o = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      ch = key_i[KEY_W-1-8*i -: 8];
      if (i >= KEY_CHARS || ch == 8'd0) begin
        ended = 1'b1;
      end
      key_o[KEY_W-1-8*i -: 8] = ended ? 8'd0 : ch;
    end
  end

endmodule

// ----- hw/rtl/rsk_cell.sv -----
// ----------------------------------------------------------------------------
// rsk_cell: one insertion sorting cell
// Holds one record; on insert it keeps, takes the new record or takes its
// left neighbor's, and on drain it takes its right neighbor's.
// ----------------------------------------------------------------------------
module rsk_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rsk_pkg::cell_ctrl_t ctrl_i,
  input  rsk_pkg::rec_t       new_rec_i,
  input  rsk_pkg::rec_t       left_rec_i,
  input  logic                left_ge_i,
  input  rsk_pkg::rec_t       right_rec_i,
  output rsk_pkg::rec_t       rec_o,
  output logic                ge_o
);
  import rsk_pkg::*;

  logic                valid_q, valid_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [WEIGHT_W-1:0] weight_q, weight_d;
  logic [INDEX_W-1:0]  index_q, index_d;

  // An empty cell counts as holding an infinitely large key. Ties also place
  // the new record first, since it is the later arrival.
  assign ge_o = !valid_q || (key_q >= new_rec_i.key);

  always_comb begin
    rec_t nxt;
    nxt = '{valid: valid_q, key: key_q, weight: weight_q, index: index_q};
    if (ctrl_i.shift) begin
      nxt = right_rec_i;
    end else if (ctrl_i.insert) begin
      if (left_ge_i) begin
        nxt = left_rec_i;
      end else if (ge_o) begin
        nxt = new_rec_i;
      end
    end
    valid_d  = nxt.valid;
    key_d    = nxt.key;
    weight_d = nxt.weight;
    index_d  = nxt.index;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    weight_q <= weight_d;
    index_q  <= index_d;
  end

  assign rec_o = '{valid: valid_q, key: key_q, weight: weight_q, index: index_q};

endmodule

// ----- hw/rtl/record_sort_by_text_key.sv -----
// ----------------------------------------------------------------------------
// record_sort_by_text_key: streaming sorter for text-keyed records
// Loads records into a chain of insertion cells and drains them in key order.
// ----------------------------------------------------------------------------
// Usage: each input beat loads one record and tags it with its arrival index
// within the set. Loading takes one beat per cycle, since every cell compares
// its own key with the incoming one in parallel and the chain shifts right of
// the insertion point in the same cycle. A beat with last_in set ends the set;
// from the next cycle the block emits the records in ascending key order, one
// result beat per cycle while the sink is ready, read from the head cell as
// the chain shifts toward it. Records with equal keys come out in reverse
// arrival order. The final result carries last_out. No input is taken during
// the drain, so the next set waits until the final result has been taken.
// Loads arriving while MAX_RECORDS records are stored are taken but dropped;
// if such a beat carries last_in, the stored set is still emitted.
module record_sort_by_text_key #(
  parameter int MAX_RECORDS = rsk_pkg::MAX_RECORDS_DEF,
  parameter int KEY_CHARS   = rsk_pkg::KEY_CHARS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rsk_in_if.sink    in_i,
  rsk_out_if.source out_o
);
  import rsk_pkg::*;

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             draining_q, draining_d;

  logic             in_acc, out_acc, full;
  logic [KEY_W-1:0] norm_key;
  rec_t             new_rec;
  cell_ctrl_t       ctrl;

  rec_t cell_rec [MAX_RECORDS];
  logic cell_ge  [MAX_RECORDS];

  // Input side is closed while the sorted set drains.
  assign in_i.ready = !draining_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign full       = (count_q == CNT_W'(MAX_RECORDS));

  rsk_normalize #(
    .KEY_CHARS(KEY_CHARS)
  ) u_normalize (
    .key_i({in_i.key_high, in_i.key_low}),
    .key_o(norm_key)
  );

  assign new_rec = '{valid: 1'b1, key: norm_key, weight: in_i.weight,
                     index: INDEX_W'(count_q)};

  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_acc;

  // The chain: cell 0 holds the smallest key. Inserts push the tail right,
  // draining pulls everything one place left.
  for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
    rec_t left_rec, right_rec;
    logic left_ge;

    if (g == 0) begin : g_head
      assign left_rec = '0;
      assign left_ge  = 1'b0;
    end else begin : g_body
      assign left_rec = cell_rec[g-1];
      assign left_ge  = cell_ge[g-1];
    end

    if (g == MAX_RECORDS - 1) begin : g_tail
      assign right_rec = '0;
    end else begin : g_inner
      assign right_rec = cell_rec[g+1];
    end

    rsk_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .new_rec_i  (new_rec),
      .left_rec_i (left_rec),
      .left_ge_i  (left_ge),
      .right_rec_i(right_rec),
      .rec_o      (cell_rec[g]),
      .ge_o       (cell_ge[g])
    );
  end

  // The head cell is the output register; the result is final when the
  // cell behind it is empty.
  assign out_o.valid         = draining_q && cell_rec[0].valid;
  assign out_o.out_key_high  = cell_rec[0].key[KEY_W-1 -: KEY_HIGH_W];
  assign out_o.out_key_low   = cell_rec[0].key[KEY_LOW_W-1:0];
  assign out_o.out_weight    = cell_rec[0].weight;
  assign out_o.arrival_index = cell_rec[0].index;
  assign out_o.last_out      = !cell_rec[1].valid;

  always_comb begin
    count_d    = count_q;
    draining_d = draining_q;
    if (ctrl.insert) begin
      count_d = count_q + CNT_W'(1);
    end
    if (in_acc && in_i.last_in) begin
      draining_d = 1'b1;
    end
    if (out_acc && out_o.last_out) begin
      draining_d = 1'b0;
      count_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      draining_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      draining_q <= draining_d;
    end
  end

  // The two head cells of the chain stay in key order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_rec[0].valid && cell_rec[1].valid) |-> (cell_rec[0].key <= cell_rec[1].key))
    else $error("sorting chain out of order at its head");

  // The second cell is never occupied while the head cell is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_rec[1].valid |-> cell_rec[0].valid)
    else $error("gap in the sorting chain");

  // The fill count never exceeds the chain length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RECORDS))
    else $error("record count beyond capacity");

  // A beat ending the set starts the drain in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.last_in) |=> (draining_q && out_o.valid))
    else $error("drain did not start after the final load");

  // After the final result the chain is empty and loading resumes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.last_out) |=> (!draining_q && count_q == '0 && !cell_rec[0].valid))
    else $error("chain not empty after the final result");

endmodule

// ----- test/record_sort_by_text_key_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// record_sort_by_text_key_tb: self-checking bench for the text-key record sorter
// Loads sets of records, predicts the sorted drain order of each set in the
// bench and compares every result beat field by field against that order.
// ----------------------------------------------------------------------------
module record_sort_by_text_key_tb;
  import rsk_pkg::*;

  localparam int MAX_RECS     = MAX_RECORDS_DEF;
  localparam int KEY_LEN      = KEY_CHARS_DEF;
  localparam int RESET_CYCLES = 12;
  // Any correct run keeps accepting a beat on one side or the other, even
  // with heavy stalling, so a long quiet stretch means a hang.
  localparam int QUIET_LIMIT  = 2000;
  // The block emits the first result the cycle after the set ends; a short
  // tail is enough to catch any stray beat after the last expected one.
  localparam int TAIL_CYCLES  = 16;
  localparam int REPORT_MAX   = 10;

  // One record as the sorter should emit it: the trimmed 88-bit key, the
  // weight, the arrival position within its set and the end-of-run flag.
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [WEIGHT_W-1:0] weight;
    logic [INDEX_W-1:0]  index;
    logic                last;
  } sorted_rec_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rsk_in_if  in_if ();
  rsk_out_if out_if ();

  record_sort_by_text_key #(
    .MAX_RECORDS (MAX_RECS),
    .KEY_CHARS   (KEY_LEN)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Records of the set being loaded, and the sorted results still owed.
  sorted_rec_t held_recs [MAX_RECS];
  int          held_count;
  sorted_rec_t owed_results [$];

  // Recently used keys, reused so that equal keys show up in random sets.
  logic [KEY_W-1:0] key_pool [$];

  // Handshake pressure of the current phase, in percent.
  int idle_pct  = 0;
  int stall_pct = 0;

  int errors        = 0;
  int loads_kept    = 0;
  int loads_dropped = 0;
  int sets_sorted   = 0;
  int results_seen  = 0;
  int quiet_cycles  = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // The key is a C string of up to KEY_LEN characters: everything from the
  // first zero byte on, and everything past KEY_LEN, is stored as zero.
  function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] k;
    bit               ended;
    k     = raw;
    ended = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (i >= KEY_LEN || k[KEY_W-1-8*i -: 8] == 8'h00) ended = 1'b1;
      if (ended) k[KEY_W-1-8*i -: 8] = 8'h00;
    end
    return k;
  endfunction

  // Stores one accepted record and, when it closes the set, queues the whole
  // set in drain order. The block's cells place the new record first on a tie,
  // so equal keys leave newest first: each record is placed ahead of every
  // record already placed whose key is not smaller.
  task automatic take_load(input logic [KEY_W-1:0] raw_key,
                           input logic [WEIGHT_W-1:0] weight, input logic last);
    sorted_rec_t rec;
    sorted_rec_t run [$];
    int          pos;
    if (held_count < MAX_RECS) begin
      rec.key    = trim_key(raw_key);
      rec.weight = weight;
      rec.index  = INDEX_W'(held_count);
      rec.last   = 1'b0;
      held_recs[held_count] = rec;
      held_count++;
      loads_kept++;
    end else begin
      loads_dropped++;
    end
    if (!last) return;
    for (int i = 0; i < held_count; i++) begin
      rec = held_recs[i];
      pos = run.size();
      while (pos > 0 && run[pos-1].key >= rec.key) pos--;
      run.insert(pos, rec);
    end
    foreach (run[i]) begin
      run[i].last = (i == run.size() - 1);
      owed_results.push_back(run[i]);
    end
    held_count = 0;
    sets_sorted++;
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic note_error(input string msg);
    errors++;
    if (errors <= REPORT_MAX) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_result();
    sorted_rec_t got;
    sorted_rec_t want;
    got.key    = {out_if.out_key_high, out_if.out_key_low};
    got.weight = out_if.out_weight;
    got.index  = out_if.arrival_index;
    got.last   = out_if.last_out;
    results_seen++;
    if (owed_results.size() == 0) begin
      note_error($sformatf("result beat with none owed: key=%h weight=%0d index=%0d last=%b",
                           got.key, got.weight, got.index, got.last));
      return;
    end
    want = owed_results.pop_front();
    if (got.key !== want.key || got.weight !== want.weight ||
        got.index !== want.index || got.last !== want.last) begin
      note_error($sformatf({"result %0d: expected key=%h weight=%0d index=%0d last=%b, ",
                            "got key=%h weight=%0d index=%0d last=%b"},
                           results_seen, want.key, want.weight, want.index, want.last,
                           got.key, got.weight, got.index, got.last));
    end
  endtask

  // Both channels are observed in one process so that a load and a result
  // beat on the same edge are always handled in the same order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        take_load({in_if.key_high, in_if.key_low}, in_if.weight, in_if.last_in);
      end
      if (out_if.valid && out_if.ready) begin
        check_result();
      end
    end
  end

  // The result side stalls at random with the probability of the phase.
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: ends the run after too many cycles without any beat.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d results still owed",
               quiet_cycles, owed_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offers one record and returns on the edge at which it is accepted. Valid
  // stays high afterwards; the next call either replaces the beat or idles.
  task automatic send_record(input logic [KEY_W-1:0] key,
                             input logic [WEIGHT_W-1:0] weight, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.key_high <= key[KEY_W-1 -: KEY_HIGH_W];
    in_if.key_low  <= key[KEY_LOW_W-1:0];
    in_if.weight   <= weight;
    in_if.last_in  <= last;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
  endtask

  // Holds the load side idle until every owed result has been checked.
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (owed_results.size() != 0);
  endtask

  // Packs text left-aligned into the 88-bit key, padded with zeros.
  function automatic logic [KEY_W-1:0] text_key(input string s);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < KEY_BYTES; i++) k[KEY_W-1-8*i -: 8] = s[i];
    return k;
  endfunction

  // Random keys of four kinds: raw bits, short strings over a tiny alphabet
  // (prefixes and ties), repeats of recent keys with junk after the end, and
  // full-range bytes cut short by a zero at a random place.
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    int               len;
    bit               ended;
    case ($urandom_range(3))
      0: k = {$urandom, $urandom, KEY_LOW_W'($urandom)};
      1: begin
        len = $urandom_range(0, KEY_BYTES);
        k   = '0;
        for (int i = 0; i < len; i++) k[KEY_W-1-8*i -: 8] = 8'("A" + $urandom_range(0, 2));
      end
      2: begin
        if (key_pool.size() == 0) begin
          k = text_key("POOL");
        end else begin
          k = trim_key(key_pool[$urandom_range(key_pool.size() - 1)]);
        end
        ended = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++) begin
          if (k[KEY_W-1-8*i -: 8] == 8'h00) ended = 1'b1;
          if (ended && $urandom_range(1)) k[KEY_W-1-8*i -: 8] = 8'($urandom);
        end
      end
      default: begin
        for (int i = 0; i < KEY_BYTES; i++) k[KEY_W-1-8*i -: 8] = 8'($urandom_range(1, 255));
        len = $urandom_range(0, KEY_BYTES - 1);
        k[KEY_W-1-8*len -: 8] = 8'h00;
      end
    endcase
    key_pool.push_back(k);
    if (key_pool.size() > 16) void'(key_pool.pop_front());
    return k;
  endfunction

  // Sends whole sets until about the given number of loads went out. Most
  // sets are short; about one in ten is up to max_size records long.
  task automatic run_random_sets(input int budget, input int max_size);
    int sent;
    int size;
    sent = 0;
    while (sent < budget) begin
      size = ($urandom_range(9) == 0) ? $urandom_range(13, max_size) : $urandom_range(1, 12);
      for (int i = 0; i < size; i++) begin
        send_record(random_key(), WEIGHT_W'($urandom), i == size - 1);
      end
      sent += size;
      if ($urandom_range(7) == 0) wait_for_drain();
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes: all-ones and all-zero keys and weights, a key whose ninth
  // character ends it, and a key whose first character ends it.
  task automatic test_field_extremes();
    send_record({KEY_W{1'b1}}, {WEIGHT_W{1'b1}}, 1'b0);
    send_record('0, '0, 1'b0);
    send_record(text_key("A"), WEIGHT_W'(1), 1'b0);
    send_record({64'hFFFF_FFFF_FFFF_FFFF, 24'h00_0000}, WEIGHT_W'(2), 1'b0);
    send_record({"ABCDEFGH", 24'h00_7FFF}, WEIGHT_W'(3), 1'b0);
    send_record({8'h00, 56'hFF_FFFF_FFFF_FFFF, 24'hFF_FFFF}, {WEIGHT_W{1'b1}}, 1'b1);
  endtask

  // A set of one: the closing beat loads its record first, then drains it.
  task automatic test_single_record();
    send_record(text_key("SOLO"), WEIGHT_W'(42), 1'b1);
  endtask

  // Equal keys, one of them equal only after trimming, must leave newest
  // first; a prefix sorts before and a longer key after the group.
  task automatic test_equal_keys();
    send_record(text_key("DELTA"), WEIGHT_W'(10), 1'b0);
    send_record(text_key("DELTA"), WEIGHT_W'(11), 1'b0);
    send_record({"DELTA", 8'h00, "JUNKS"}, WEIGHT_W'(12), 1'b0);
    send_record(text_key("DELT"), WEIGHT_W'(13), 1'b0);
    send_record(text_key("DELTA"), WEIGHT_W'(14), 1'b0);
    send_record(text_key("DELTAX"), WEIGHT_W'(15), 1'b1);
  endtask

  // Junk after the terminating zero is ignored, and characters compare as
  // unsigned bytes, so 0x80 sorts above 0x7F.
  task automatic test_key_trimming();
    send_record({"AB", 8'h00, "CCCCCCCC"}, WEIGHT_W'(20), 1'b0);
    send_record({"AB", 8'h00, "DDDDDDDD"}, WEIGHT_W'(21), 1'b0);
    send_record(text_key("ABC"), WEIGHT_W'(22), 1'b0);
    send_record({8'h80, 80'h0}, WEIGHT_W'(23), 1'b0);
    send_record({8'h7F, 8'hFF, 72'h0}, WEIGHT_W'(24), 1'b1);
  endtask

  // Random sets under each handshake pressure: none, a slow sender, a slow
  // receiver, and light idling on both sides.
  task automatic test_random_phases();
    int idle_set  [4] = '{0, 54, 0, 8};
    int stall_set [4] = '{0, 0, 54, 8};
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      run_random_sets(75, 40);
      wait_for_drain();
    end
  endtask

  // A set that exactly fills the store, then one that overflows it: the
  // extra loads are dropped and the closing beat, itself dropped, still
  // starts the drain of the stored records.
  task automatic test_full_store();
    idle_pct  = 8;
    stall_pct = 8;
    for (int i = 0; i < MAX_RECS; i++) begin
      send_record(random_key(), WEIGHT_W'($urandom), i == MAX_RECS - 1);
    end
    wait_for_drain();
    for (int i = 0; i < MAX_RECS + 3; i++) begin
      send_record(random_key(), WEIGHT_W'($urandom), i == MAX_RECS + 2);
    end
    wait_for_drain();
  endtask

  initial begin
    in_if.valid    = 1'b0;
    in_if.key_high = '0;
    in_if.key_low  = '0;
    in_if.weight   = '0;
    in_if.last_in  = 1'b0;
    held_count     = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_single_record();
    wait_for_drain();
    test_equal_keys();
    test_key_trimming();
    wait_for_drain();
    test_random_phases();
    test_full_store();

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Summary: %0d records loaded and %0d dropped on a full store, in %0d sorted sets.",
             loads_kept, loads_dropped, sets_sorted);
    $display("Summary: %0d result beats checked under four pressure phases, %0d errors.",
             results_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/rsk_pkg.sv
hw/rtl/rsk_if.sv
hw/rtl/rsk_normalize.sv
hw/rtl/rsk_cell.sv
hw/rtl/record_sort_by_text_key.sv
test/record_sort_by_text_key_tb.sv
